// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every clock edge outside reset.
`define ASSERT_SYNC(name, clk, rst, prop, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Same-cycle implication checked outside reset.
`define ASSERT_IMPL(name, clk, rst, ante, cons, msg) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== rtl/slt_pkg.sv =====
// ----------------------------------------------------------------------------
// slt_pkg
// Types and constants shared by the sorted list table.
// ----------------------------------------------------------------------------
`default_nettype none

package slt_pkg;

   localparam int DEPTH_DEFAULT       = 16;
   localparam int VALUE_WIDTH_DEFAULT = 32;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_REMOVE = 2'd1,
      OP_CLEAR  = 2'd2,
      OP_DUMP   = 2'd3
   } slt_op_type;

   typedef enum logic [2:0] {
      ST_DONE      = 3'd0,
      ST_NOT_FOUND = 3'd1,
      ST_FULL      = 3'd2,
      ST_ENTRY     = 3'd3,
      ST_EMPTY     = 3'd4
   } slt_status_type;

   // what every cell does in a cycle
   typedef enum logic [2:0] {
      CA_HOLD    = 3'd0,
      CA_COMPARE = 3'd1,
      CA_INSERT  = 3'd2,
      CA_REMOVE  = 3'd3,
      CA_ROTATE  = 3'd4
   } slt_action_type;

   typedef struct packed {
      slt_action_type action;
      logic           occupied;   // cell index below the count
      logic           tail;       // cell holds the last stored entry
   } slt_cell_ctl_type;

   typedef enum logic [1:0] {
      S_IDLE = 2'd0,
      S_EXEC = 2'd1,
      S_DUMP = 2'd2
   } slt_state_type;

endpackage

`default_nettype wire

// ===== rtl/slt_channels.sv =====
// ----------------------------------------------------------------------------
// slt_channels
// Valid/ready channel interfaces for request and response words.
// ----------------------------------------------------------------------------
`default_nettype none

interface slt_req_if #(
   parameter int VALUE_WIDTH = 32
);
   logic                   valid;
   logic                   ready;
   logic [1:0]             opcode;
   logic [VALUE_WIDTH-1:0] value;

   modport source (output valid, output opcode, output value, input ready);
   modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface slt_rsp_if #(
   parameter int VALUE_WIDTH = 32,
   parameter int DEPTH       = 16
);
   logic                         valid;
   logic                         ready;
   logic [2:0]                   status;
   logic [VALUE_WIDTH-1:0]       entry_value;
   logic                         last;
   logic [$clog2(DEPTH+1)-1:0]   entry_count;

   modport source (output valid, output status, output entry_value, output last,
                   output entry_count, input ready);
   modport sink   (input valid, input status, input entry_value, input last,
                   input entry_count, output ready);
endinterface

`default_nettype wire

// ===== rtl/slt_cell.sv =====
// ----------------------------------------------------------------------------
// slt_cell
// One slot of the sorted chain: holds an entry, compares it against the key
// and shifts from either neighbor on insert, remove and dump rotation.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_cell #(
   parameter int VALUE_WIDTH = 32
) (
   input  logic                          clock,
   input  slt_pkg::slt_cell_ctl_type     ctl,
   input  logic signed [VALUE_WIDTH-1:0] key,
   input  logic signed [VALUE_WIDTH-1:0] left_entry,
   input  logic                          left_lt,
   input  logic signed [VALUE_WIDTH-1:0] right_entry,
   input  logic signed [VALUE_WIDTH-1:0] wrap_entry,
   output logic signed [VALUE_WIDTH-1:0] entry,
   output logic                          lt,
   output logic                          eq
);
   import slt_pkg::*;

   logic signed [VALUE_WIDTH-1:0] entry_ff, entry_in;
   logic                          lt_ff, lt_in;
   logic                          eq_ff, eq_in;

   always_comb begin
      entry_in = entry_ff;
      lt_in    = lt_ff;
      eq_in    = eq_ff;
      unique case (ctl.action)
         CA_HOLD: begin
         end
         CA_COMPARE: begin
            lt_in = ctl.occupied && (entry_ff < key);
            eq_in = ctl.occupied && (entry_ff == key);
         end
         // insert point is the first cell not below the key
         CA_INSERT: begin
            if (!left_lt) begin
               entry_in = left_entry;
            end else if (!lt_ff) begin
               entry_in = key;
            end
         end
         CA_REMOVE: begin
            if (!lt_ff) begin
               entry_in = right_entry;
            end
         end
         CA_ROTATE: begin
            entry_in = ctl.tail ? wrap_entry : right_entry;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      lt_ff    <= lt_in;
      eq_ff    <= eq_in;
   end

   assign entry = entry_ff;
   assign lt    = lt_ff;
   assign eq    = eq_ff;

endmodule

`default_nettype wire

// ===== rtl/slt_ctrl.sv =====
// ----------------------------------------------------------------------------
// slt_ctrl
// Sequencer of the sorted list table: accepts requests, drives the cell
// action, keeps the count and owns the response register.
// ----------------------------------------------------------------------------
`default_nettype none

module slt_ctrl #(
   parameter int DEPTH       = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   slt_req_if.sink                        req,
   slt_rsp_if.source                      rsp,
   input  logic                           found,
   input  logic [VALUE_WIDTH-1:0]         head_entry,
   output slt_pkg::slt_action_type        action,
   output logic [VALUE_WIDTH-1:0]         key,
   output logic [$clog2(DEPTH+1)-1:0]     count
);
   import slt_pkg::*;

   localparam int CountWidth = $clog2(DEPTH + 1);

   slt_state_type          state_ff, state_in;
   slt_op_type             op_ff, op_in;
   logic [VALUE_WIDTH-1:0] key_ff, key_in;
   logic [CountWidth-1:0]  count_ff, count_in;
   logic [CountWidth-1:0]  idx_ff, idx_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   slt_status_type         rsp_status_ff, rsp_status_in;
   logic [VALUE_WIDTH-1:0] rsp_value_ff, rsp_value_in;
   logic                   rsp_last_ff, rsp_last_in;
   logic [CountWidth-1:0]  rsp_count_ff, rsp_count_in;

   logic                   out_free;
   logic                   load;
   logic                   dump_last;

   assign out_free  = !rsp_valid_ff || rsp.ready;
   assign dump_last = (CountWidth'(idx_ff + 1'b1) == count_ff);

   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      rsp_status_in = rsp_status_ff;
      rsp_value_in  = rsp_value_ff;
      rsp_last_in   = rsp_last_ff;
      rsp_count_in  = rsp_count_ff;
      action        = CA_HOLD;
      req.ready     = 1'b0;
      load          = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            req.ready = 1'b1;
            if (req.valid) begin
               action   = CA_COMPARE;
               op_in    = slt_op_type'(req.opcode);
               key_in   = req.value;
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (out_free) begin
               load          = 1'b1;
               rsp_status_in = ST_DONE;
               rsp_value_in  = '0;
               rsp_last_in   = 1'b1;
               state_in      = S_IDLE;
               unique case (op_ff)
                  OP_INSERT: begin
                     if (count_ff == CountWidth'(DEPTH)) begin
                        rsp_status_in = ST_FULL;
                     end else begin
                        action   = CA_INSERT;
                        count_in = CountWidth'(count_ff + 1'b1);
                     end
                  end
                  OP_REMOVE: begin
                     if (found) begin
                        action   = CA_REMOVE;
                        count_in = CountWidth'(count_ff - 1'b1);
                     end else begin
                        rsp_status_in = ST_NOT_FOUND;
                     end
                  end
                  OP_CLEAR: begin
                     count_in = '0;
                  end
                  OP_DUMP: begin
                     if (count_ff == '0) begin
                        rsp_status_in = ST_EMPTY;
                     end else begin
                        load     = 1'b0;
                        idx_in   = '0;
                        state_in = S_DUMP;
                     end
                  end
               endcase
               rsp_count_in = count_in;
            end
         end
         // head cell is emitted, then the occupied cells rotate by one
         S_DUMP: begin
            if (out_free) begin
               load          = 1'b1;
               action        = CA_ROTATE;
               rsp_status_in = ST_ENTRY;
               rsp_value_in  = head_entry;
               rsp_last_in   = dump_last;
               rsp_count_in  = count_ff;
               idx_in        = CountWidth'(idx_ff + 1'b1);
               if (dump_last) begin
                  state_in = S_IDLE;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rsp_valid_in = load || (rsp_valid_ff && !rsp.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff         <= op_in;
      key_ff        <= key_in;
      idx_ff        <= idx_in;
      rsp_status_ff <= rsp_status_in;
      rsp_value_ff  <= rsp_value_in;
      rsp_last_ff   <= rsp_last_in;
      rsp_count_ff  <= rsp_count_in;
   end

   // compare runs on the incoming value in the accept cycle
   assign key   = (state_ff == S_IDLE) ? req.value : key_ff;
   assign count = count_ff;

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.status      = rsp_status_ff;
   assign rsp.entry_value = rsp_value_ff;
   assign rsp.last        = rsp_last_ff;
   assign rsp.entry_count = rsp_count_ff;

endmodule

`default_nettype wire

// ===== rtl/sorted_list_table.sv =====
// ----------------------------------------------------------------------------
// sorted_list_table
// Bounded multiset of signed values kept in ascending order in a cell chain.
// ----------------------------------------------------------------------------
// Request channel req_bus carries an opcode (insert, remove, clear, dump) and
// a signed value. Response channel rsp_bus returns status, entry value, last
// flag and the entry count after the operation.
// Insert, remove and clear give one response word each: the cells compare
// against the value in the accept cycle, and an insert or remove shifts them
// once the response register is free. Requests are taken only in the idle
// state. Dump gives one word per stored entry, one per cycle while the
// receiver takes them; an empty store gives a single word.
// The head cell feeds the response register and the chain rotates by one
// entry per word, so the store is back in order when the dump ends.
// A stalled receiver holds the response register; one more request may be
// taken, then the sequencer waits with the request side closed until the
// response register frees.
// Reset empties the store and drops any pending response; no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module sorted_list_table #(
   parameter int DEPTH       = slt_pkg::DEPTH_DEFAULT,
   parameter int VALUE_WIDTH = slt_pkg::VALUE_WIDTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   slt_req_if.sink   req_bus,
   slt_rsp_if.source rsp_bus
);
   import slt_pkg::*;

   localparam int CountWidth = $clog2(DEPTH + 1);

   slt_action_type                action;
   logic [VALUE_WIDTH-1:0]        key;
   logic [CountWidth-1:0]         count;
   logic                          found;

   slt_cell_ctl_type              cell_ctl [DEPTH];
   logic signed [VALUE_WIDTH-1:0] entry    [DEPTH];
   logic [DEPTH-1:0]              lt;
   logic [DEPTH-1:0]              eq;

   slt_ctrl #(
      .DEPTH       (DEPTH),
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .rsp        (rsp_bus),
      .found      (found),
      .head_entry (entry[0]),
      .action     (action),
      .key        (key),
      .count      (count)
   );

   // store is sorted, so any occupied match means the value is present
   assign found = |eq;

   for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic signed [VALUE_WIDTH-1:0] left_entry;
      logic                          left_lt;
      logic signed [VALUE_WIDTH-1:0] right_entry;

      assign cell_ctl[i] = '{action:   action,
                             occupied: (CountWidth'(i) < count),
                             tail:     (CountWidth'(i + 1) == count)};

      if (i == 0) begin : g_head
         assign left_entry = key;
         assign left_lt    = 1'b1;
      end else begin : g_body
         assign left_entry = entry[i-1];
         assign left_lt    = lt[i-1];
      end

      if (i == DEPTH - 1) begin : g_end
         assign right_entry = entry[i];
      end else begin : g_mid
         assign right_entry = entry[i+1];
      end

      slt_cell #(
         .VALUE_WIDTH (VALUE_WIDTH)
      ) u_cell (
         .clock       (clock),
         .ctl         (cell_ctl[i]),
         .key         (key),
         .left_entry  (left_entry),
         .left_lt     (left_lt),
         .right_entry (right_entry),
         .wrap_entry  (entry[0]),
         .entry       (entry[i]),
         .lt          (lt[i]),
         .eq          (eq[i])
      );
   end

   `ASSERT_SYNC(a_count_bound, clock, reset, count <= CountWidth'(DEPTH), "count above depth")
   `ASSERT_SYNC(a_one_at_a_time, clock, reset, (req_bus.valid && req_bus.ready) |=> !req_bus.ready, "request taken while busy")
   `ASSERT_IMPL(a_single_last, clock, reset, rsp_bus.valid && (rsp_bus.status != ST_ENTRY), rsp_bus.last && (rsp_bus.entry_value == '0), "single word response malformed")
   `ASSERT_IMPL(a_dump_count, clock, reset, rsp_bus.valid && (rsp_bus.status == ST_ENTRY), rsp_bus.entry_count != '0, "dump word with empty store")

endmodule

`default_nettype wire

// ===== sim/sorted_list_table_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_list_table_tb
// Self-checking bench for the sorted list table. A short table of directed
// words covers the empty, full and absent-value cases and the value extremes.
// Random insert/remove/dump/clear traffic follows in three phases, the first
// two with throttling on both channels. Every response word is checked
// against an internal copy of the sorted store.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_list_table_tb;
   import slt_pkg::*;

   localparam int LIST_DEPTH = DEPTH_DEFAULT;
   localparam int VALUE_W    = VALUE_WIDTH_DEFAULT;
   localparam int RANDOM_PER_PHASE = 145;

   typedef struct packed {
      slt_status_type status;
      logic [31:0]    entry_value;
      logic           last;
      logic [4:0]     entry_count;
   } list_word_type;

   typedef struct packed {
      slt_op_type     op;
      logic [31:0]    value;
      logic [4:0]     reps;
      logic           typed;
      slt_status_type status;
      logic [4:0]     count;
   } list_step_type;

   logic clock;
   logic reset;

   slt_req_if #(.VALUE_WIDTH(VALUE_W)) req_bus ();
   slt_rsp_if #(.VALUE_WIDTH(VALUE_W), .DEPTH(LIST_DEPTH)) rsp_bus ();

   sorted_list_table #(
      .DEPTH      (LIST_DEPTH),
      .VALUE_WIDTH(VALUE_W)
   ) DUT (
      .clock  (clock),
      .reset  (reset),
      .req_bus(req_bus),
      .rsp_bus(rsp_bus)
   );

   // shadow of the store
   logic signed [31:0] shadow_values [LIST_DEPTH];
   int                 shadow_count;
   list_word_type      pending_words [$];

   int mismatch_count;
   int send_idle_pct;
   int recv_idle_pct;

   // typed rows only where the answer is obvious; the rest go through the shadow
   list_step_type directed_steps [0:14] = '{
      '{OP_DUMP,   32'h0000_0000, 5'd1, 1'b1, ST_EMPTY,     5'd0},
      '{OP_REMOVE, 32'h0000_0005, 5'd1, 1'b1, ST_NOT_FOUND, 5'd0},
      '{OP_INSERT, 32'h7FFF_FFFF, 5'd1, 1'b0, ST_DONE,      5'd0},
      '{OP_INSERT, 32'h8000_0000, 5'd1, 1'b0, ST_DONE,      5'd0},
      '{OP_INSERT, 32'h0000_0000, 5'd1, 1'b0, ST_DONE,      5'd0},
      '{OP_INSERT, 32'hFFFF_FFFF, 5'd1, 1'b0, ST_DONE,      5'd0},
      '{OP_REMOVE, 32'h0000_1234, 5'd1, 1'b1, ST_NOT_FOUND, 5'd4},
      '{OP_INSERT, 32'h5555_5555, 5'd6, 1'b0, ST_DONE,      5'd0},
      '{OP_INSERT, 32'hAAAA_AAAA, 5'd6, 1'b0, ST_DONE,      5'd0},
      '{OP_INSERT, 32'h0000_0000, 5'd1, 1'b1, ST_FULL,      5'd16},
      '{OP_DUMP,   32'hFFFF_FFFF, 5'd1, 1'b0, ST_DONE,      5'd0},
      '{OP_REMOVE, 32'h8000_0000, 5'd1, 1'b0, ST_DONE,      5'd0},
      '{OP_REMOVE, 32'h7FFF_FFFF, 5'd1, 1'b0, ST_DONE,      5'd0},
      '{OP_CLEAR,  32'hFFFF_FFFF, 5'd1, 1'b1, ST_DONE,      5'd0},
      '{OP_DUMP,   32'h0000_0000, 5'd1, 1'b1, ST_EMPTY,     5'd0}
   };

   task automatic report_mismatch(input string what);
      if (mismatch_count < 100)
         $display("%0t ns: mismatch: %s", $time, what);
      mismatch_count++;
   endtask

   function automatic void push_word(input slt_status_type st, input logic [31:0] val,
                                     input logic lst);
      list_word_type w;
      w.status      = st;
      w.entry_value = val;
      w.last        = lst;
      w.entry_count = shadow_count[4:0];
      pending_words.push_back(w);
   endfunction

   // updates the shadow store and queues the words one request produces
   function automatic void apply_list_op(input slt_op_type op, input logic signed [31:0] val);
      int pos;
      int i;
      pos = 0;
      case (op)
         OP_INSERT: begin
            if (shadow_count >= LIST_DEPTH) begin
               push_word(ST_FULL, 32'd0, 1'b1);
            end else begin
               while (pos < shadow_count && shadow_values[pos] < val)
                  pos++;
               for (i = shadow_count; i > pos; i--)
                  shadow_values[i] = shadow_values[i-1];
               shadow_values[pos] = val;
               shadow_count++;
               push_word(ST_DONE, 32'd0, 1'b1);
            end
         end
         OP_REMOVE: begin
            while (pos < shadow_count && shadow_values[pos] < val)
               pos++;
            if (pos >= shadow_count || shadow_values[pos] != val) begin
               push_word(ST_NOT_FOUND, 32'd0, 1'b1);
            end else begin
               for (i = pos; i + 1 < shadow_count; i++)
                  shadow_values[i] = shadow_values[i+1];
               shadow_count--;
               push_word(ST_DONE, 32'd0, 1'b1);
            end
         end
         OP_CLEAR: begin
            shadow_count = 0;
            push_word(ST_DONE, 32'd0, 1'b1);
         end
         default: begin
            if (shadow_count == 0)
               push_word(ST_EMPTY, 32'd0, 1'b1);
            else
               for (i = 0; i < shadow_count; i++)
                  push_word(ST_ENTRY, shadow_values[i], i + 1 == shadow_count);
         end
      endcase
   endfunction

   // valid stays up across back-to-back words; it only drops on a gap
   task automatic send_word(input slt_op_type op, input logic [31:0] val,
                            input logic typed, input list_word_type typed_word);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid  <= 1'b1;
      req_bus.opcode <= op;
      req_bus.value  <= val;
      @(posedge clock);
      while (!req_bus.ready)
         @(posedge clock);
      apply_list_op(op, val);
      if (typed)
         pending_words[pending_words.size()-1] = typed_word;
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom;
         default: return 32'($urandom_range(0, 16)) - 32'd8;
      endcase
   endfunction

   task automatic run_random(input int n);
      int            k;
      int            r;
      slt_op_type    op;
      logic [31:0]   val;
      list_word_type none;
      none = '0;
      for (k = 0; k < n; k++) begin
         r   = $urandom_range(0, 99);
         val = pick_value();
         if (r < 46) begin
            op = OP_INSERT;
         end else if (r < 80) begin
            op = OP_REMOVE;
            // mostly hit something that is stored
            if (shadow_count > 0 && $urandom_range(0, 99) < 65)
               val = shadow_values[$urandom_range(0, shadow_count - 1)];
         end else if (r < 95) begin
            op  = OP_DUMP;
            val = $urandom;
         end else begin
            op  = OP_CLEAR;
            val = $urandom;
         end
         send_word(op, val, 1'b0, none);
      end
   endtask

   task automatic drain_pending();
      req_bus.valid <= 1'b0;
      while (pending_words.size() != 0)
         @(posedge clock);
   endtask

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_bus.ready <= 1'b0;
      else
         rsp_bus.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   always @(posedge clock) begin : rsp_check
      list_word_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_words.size() == 0) begin
            report_mismatch($sformatf("unexpected word status=%0d value=%h",
                                      rsp_bus.status, rsp_bus.entry_value));
         end else begin
            want = pending_words.pop_front();
            if (rsp_bus.status != want.status)
               report_mismatch($sformatf("status %0d, want %0d",
                                         rsp_bus.status, want.status));
            if (rsp_bus.entry_value != want.entry_value)
               report_mismatch($sformatf("entry_value %h, want %h",
                                         rsp_bus.entry_value, want.entry_value));
            if (rsp_bus.last != want.last)
               report_mismatch($sformatf("last %0b, want %0b", rsp_bus.last, want.last));
            if (rsp_bus.entry_count != want.entry_count)
               report_mismatch($sformatf("entry_count %0d, want %0d",
                                         rsp_bus.entry_count, want.entry_count));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("FAILURE");
      $finish;
   end

   initial begin : stimulus
      int            s;
      int            k;
      list_word_type typed_word;
      mismatch_count = 0;
      shadow_count   = 0;
      send_idle_pct  = 26;
      recv_idle_pct  = 88;
      reset          <= 1'b1;
      req_bus.valid  <= 1'b0;
      req_bus.opcode <= OP_INSERT;
      req_bus.value  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      for (s = 0; s < 15; s++) begin
         typed_word.status      = directed_steps[s].status;
         typed_word.entry_value = 32'd0;
         typed_word.last        = 1'b1;
         typed_word.entry_count = directed_steps[s].count;
         for (k = 0; k < directed_steps[s].reps; k++)
            send_word(directed_steps[s].op, directed_steps[s].value,
                      directed_steps[s].typed, typed_word);
      end

      run_random(RANDOM_PER_PHASE);
      // hold off the sender until the table has answered everything
      drain_pending();
      send_idle_pct = 88;
      recv_idle_pct = 26;
      run_random(RANDOM_PER_PHASE);
      drain_pending();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(RANDOM_PER_PHASE);
      drain_pending();

      repeat (20) @(posedge clock);
      if (mismatch_count == 0 && pending_words.size() == 0)
         $display("SUCCESS");
      else
         $display("FAILURE");
      $finish;
   end

endmodule

`default_nettype wire

// ===== files.f =====
+incdir+rtl
rtl/slt_pkg.sv
rtl/slt_channels.sv
rtl/slt_cell.sv
rtl/slt_ctrl.sv
rtl/sorted_list_table.sv
sim/sorted_list_table_tb.sv
